FILE: src/phong_pixel_lighting_core_defines.svh
// ----------------------------------------------------------------------------
// Phong lighting core assertion macros
// Shared property forms used by the lighting core's self checks.
// ----------------------------------------------------------------------------
`ifndef PHONG_PIXEL_LIGHTING_CORE_DEFINES_SVH
`define PHONG_PIXEL_LIGHTING_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PHONG_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("phong lighting check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define PHONG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("phong lighting check failed");

`endif

FILE: src/phong_pkg.sv
// ----------------------------------------------------------------------------
// Phong lighting package
// Beat types, register indexes and fixed constants of the lighting core.
// ----------------------------------------------------------------------------
package phong_pkg;

    localparam int VEC_W      = 16;
    localparam int EXP_W      = 8;
    localparam int OUT_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PWR_STAGES = (1 << EXP_W) - 1;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_PLAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_TEX   = 3'd4;

    typedef struct packed {
        logic signed [VEC_W-1:0] normal_x;
        logic signed [VEC_W-1:0] normal_y;
        logic signed [VEC_W-1:0] normal_z;
        logic signed [VEC_W-1:0] eye_x;
        logic signed [VEC_W-1:0] eye_y;
        logic signed [VEC_W-1:0] eye_z;
        logic                    textured;
    } t_pix_in;

    typedef struct packed {
        logic [OUT_W-1:0] diffuse;
        logic [OUT_W-1:0] specular;
    } t_pix_out;

endpackage

FILE: src/phong_norm.sv
// ----------------------------------------------------------------------------
// Phong vector normalizer
// Pipelined 3-vector normalize: squares, sum, one root bit per stage, then
// one quotient bit per stage in three divider lanes.
// ----------------------------------------------------------------------------
module phong_norm #(
    parameter int VW  = 16,
    parameter int FB  = 14,
    parameter int SBW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic [2:0][VW-1:0] i_vec,
    input  logic [SBW-1:0]     i_sb,
    output logic               o_valid,
    output logic [2:0][FB+1:0] o_unit,
    output logic               o_ok,
    output logic [SBW-1:0]     o_sb
);

    localparam int SQW = 2 * VW;
    localparam int RTW = VW + 2;
    localparam int DRW = VW + 1;
    localparam int QW  = FB + 1;
    localparam int UW  = FB + 2;
    localparam int NSQ = VW;
    localparam int NDV = FB + 1;

    // Square stage.
    logic               r_p_v;
    logic [2:0][SQW-1:0] r_p_sq;
    logic [2:0][VW-1:0] r_p_mag;
    logic [2:0]         r_p_sgn;
    logic [SBW-1:0]     r_p_sb;
    logic [2:0][VW-1:0] n_mag;

    // Square root stages; index 0 holds the summed length squared.
    logic               r_sq_v    [NSQ+1];
    logic [SQW-1:0]     r_sq_x    [NSQ+1];
    logic [RTW-1:0]     r_sq_rem  [NSQ+1];
    logic [VW-1:0]      r_sq_root [NSQ+1];
    logic [2:0][VW-1:0] r_sq_mag  [NSQ+1];
    logic [2:0]         r_sq_sgn  [NSQ+1];
    logic [SBW-1:0]     r_sq_sb   [NSQ+1];
    logic               n_sq_v    [NSQ+1];
    logic [SQW-1:0]     n_sq_x    [NSQ+1];
    logic [RTW-1:0]     n_sq_rem  [NSQ+1];
    logic [VW-1:0]      n_sq_root [NSQ+1];
    logic [2:0][VW-1:0] n_sq_mag  [NSQ+1];
    logic [2:0]         n_sq_sgn  [NSQ+1];
    logic [SBW-1:0]     n_sq_sb   [NSQ+1];

    // Divider stages.
    logic                r_dv_v   [NDV];
    logic [2:0][DRW-1:0] r_dv_rem [NDV];
    logic [2:0][QW-1:0]  r_dv_q   [NDV];
    logic [VW-1:0]       r_dv_len [NDV];
    logic [2:0]          r_dv_sgn [NDV];
    logic [SBW-1:0]      r_dv_sb  [NDV];
    logic                n_dv_v   [NDV];
    logic [2:0][DRW-1:0] n_dv_rem [NDV];
    logic [2:0][QW-1:0]  n_dv_q   [NDV];
    logic [VW-1:0]       n_dv_len [NDV];
    logic [2:0]          n_dv_sgn [NDV];
    logic [SBW-1:0]      n_dv_sb  [NDV];

    function automatic logic [DRW:0] div_step(input logic [DRW-1:0] rem, input logic b,
                                              input logic [VW-1:0] len);
        logic [DRW-1:0] sh;
        logic           ge;
        sh = {rem[DRW-2:0], b};
        ge = (sh >= {1'b0, len});
        div_step = {(ge ? sh - {1'b0, len} : sh), ge};
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_vec[i][VW-1] ? (~i_vec[i] + VW'(1)) : i_vec[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (i_adv) begin
            r_p_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p_sq[i]  <= SQW'(n_mag[i]) * SQW'(n_mag[i]);
                r_p_sgn[i] <= i_vec[i][VW-1];
            end
            r_p_mag <= n_mag;
            r_p_sb  <= i_sb;
        end
    end

    // Digit-by-digit square root, two radicand bits per stage.
    always_comb begin
        logic [RTW-1:0] remsh;
        logic [RTW-1:0] trial;
        logic           ge;
        int             bi;
        n_sq_v[0]    = r_p_v;
        n_sq_x[0]    = r_p_sq[0] + r_p_sq[1] + r_p_sq[2];
        n_sq_rem[0]  = '0;
        n_sq_root[0] = '0;
        n_sq_mag[0]  = r_p_mag;
        n_sq_sgn[0]  = r_p_sgn;
        n_sq_sb[0]   = r_p_sb;
        for (int k = 0; k < NSQ; k++) begin
            bi    = NSQ - 1 - k;
            remsh = {r_sq_rem[k][RTW-3:0], r_sq_x[k][2*bi+1 -: 2]};
            trial = {r_sq_root[k], 2'b01};
            ge    = (remsh >= trial);
            n_sq_v[k+1]    = r_sq_v[k];
            n_sq_x[k+1]    = r_sq_x[k];
            n_sq_rem[k+1]  = ge ? remsh - trial : remsh;
            n_sq_root[k+1] = {r_sq_root[k][VW-2:0], ge};
            n_sq_mag[k+1]  = r_sq_mag[k];
            n_sq_sgn[k+1]  = r_sq_sgn[k];
            n_sq_sb[k+1]   = r_sq_sb[k];
        end
    end

    // Quotient bits above the binary point are zero, so the division starts
    // with the dividend's upper part already in the remainder.
    always_comb begin
        logic [DRW:0] st;
        n_dv_v[0]   = r_sq_v[NSQ];
        n_dv_len[0] = r_sq_root[NSQ];
        n_dv_sgn[0] = r_sq_sgn[NSQ];
        n_dv_sb[0]  = r_sq_sb[NSQ];
        for (int i = 0; i < 3; i++) begin
            st = div_step(DRW'(r_sq_mag[NSQ][i] >> 1), r_sq_mag[NSQ][i][0], r_sq_root[NSQ]);
            n_dv_rem[0][i] = st[DRW:1];
            n_dv_q[0][i]   = QW'(st[0]);
        end
        for (int j = 1; j < NDV; j++) begin
            n_dv_v[j]   = r_dv_v[j-1];
            n_dv_len[j] = r_dv_len[j-1];
            n_dv_sgn[j] = r_dv_sgn[j-1];
            n_dv_sb[j]  = r_dv_sb[j-1];
            for (int i = 0; i < 3; i++) begin
                st = div_step(r_dv_rem[j-1][i], 1'b0, r_dv_len[j-1]);
                n_dv_rem[j][i] = st[DRW:1];
                n_dv_q[j][i]   = {r_dv_q[j-1][i][QW-2:0], st[0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSQ; k++) begin
                r_sq_v[k] <= 1'b0;
            end
            for (int j = 0; j < NDV; j++) begin
                r_dv_v[j] <= 1'b0;
            end
        end else if (i_adv) begin
            for (int k = 0; k <= NSQ; k++) begin
                r_sq_v[k] <= n_sq_v[k];
            end
            for (int j = 0; j < NDV; j++) begin
                r_dv_v[j] <= n_dv_v[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k <= NSQ; k++) begin
                r_sq_x[k]    <= n_sq_x[k];
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_mag[k]  <= n_sq_mag[k];
                r_sq_sgn[k]  <= n_sq_sgn[k];
                r_sq_sb[k]   <= n_sq_sb[k];
            end
            for (int j = 0; j < NDV; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_q[j]   <= n_dv_q[j];
                r_dv_len[j] <= n_dv_len[j];
                r_dv_sgn[j] <= n_dv_sgn[j];
                r_dv_sb[j]  <= n_dv_sb[j];
            end
        end
    end

    assign o_valid = r_dv_v[NDV-1];
    assign o_ok    = (r_dv_len[NDV-1] != '0);
    assign o_sb    = r_dv_sb[NDV-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!o_ok) begin
                o_unit[i] = '0;
            end else if (r_dv_sgn[NDV-1][i]) begin
                o_unit[i] = UW'(0) - UW'(r_dv_q[NDV-1][i]);
            end else begin
                o_unit[i] = UW'(r_dv_q[NDV-1][i]);
            end
        end
    end

endmodule

FILE: src/phong_pixel_lighting_core.sv
// ----------------------------------------------------------------------------
// Phong pixel lighting core
// Per-pixel diffuse and clamped specular factors in fixed point.
// ----------------------------------------------------------------------------
// Input beats (i_valid/o_stall) carry a normal, an eye vector and a textured
// flag; output beats (o_valid/i_stall) carry the diffuse and specular factors,
// one result per input, in order. Light direction and the two specular
// exponents are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must
// write them only while idle, since the block itself does not enforce this.
// Throughput is one beat per clock while the receiver does not stall. The
// pipeline is made of the bit-per-stage root and divider pipelines of the
// normalizers and of the 255 multiplier stages of the power chain, one per
// exponent step. Reset clears every stage's valid bit and loads the register
// defaults: light (0, 0, 1.0), both exponents 32. When the receiver stalls a
// waiting result, the whole pipeline holds and o_stall rises in the same
// cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "phong_pixel_lighting_core_defines.svh"

module phong_pixel_lighting_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  phong_pkg::t_pix_in               i_pix,
    output logic                             o_valid,
    input  logic                             i_stall,
    output phong_pkg::t_pix_out              o_pix,
    input  logic                             i_cfg_we,
    input  logic [phong_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [phong_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FB   = FRAC_BITS;
    localparam int LW   = phong_pkg::VEC_W;
    localparam int UW   = FB + 2;
    localparam int PW   = UW + LW;
    localparam int EW   = 2 * UW;
    localparam int SMW  = ((PW > EW) ? PW : EW) + 2;
    localparam int DW   = ((UW > LW) ? UW : LW) + 1;
    localparam int PRW  = 2 * (FB + 1);
    localparam int NPW  = phong_pkg::PWR_STAGES;
    localparam int XW   = phong_pkg::EXP_W;
    localparam int SATW = (FB + 1 > phong_pkg::OUT_W) ? FB + 1 : phong_pkg::OUT_W;
    localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

    typedef struct packed {
        logic               tex;
        logic               eok;
        logic [FB:0]        dif;
        logic [2:0][UW-1:0] eu;
    } t_rsb;

    logic adv;

    // Configuration registers.
    logic signed [LW-1:0] r_light [3];
    logic [XW-1:0]        r_exp_plain;
    logic [XW-1:0]        r_exp_tex;

    // Normalizer outputs.
    logic               nn_v, ne_v, nr_v, ne_ok, nr_ok;
    logic [2:0][UW-1:0] nn_u, ne_u, nr_u;
    logic               nn_sb;
    logic [2:0][LW-1:0] vn, ve;
    t_rsb               rsb_in, rsb_out;

    // Dot and reflection stages.
    logic                 r_b1_v;
    logic signed [PW-1:0] r_b1_pl [3];
    logic [2:0][DW-1:0]   r_b1_d;
    logic [2:0][UW-1:0]   r_b1_eu;
    logic                 r_b1_eok;
    logic                 r_b1_tex;

    logic                 r_b2_v;
    logic [FB:0]          r_b2_dif;
    logic [2:0][DW-1:0]   r_b2_d;
    logic [2:0][UW-1:0]   r_b2_eu;
    logic                 r_b2_eok;
    logic                 r_b2_tex;

    logic                 r_c1_v;
    logic signed [EW-1:0] r_c1_pr [3];
    logic                 r_c1_ok;
    logic [FB:0]          r_c1_dif;
    logic                 r_c1_tex;

    // Power chain; index 0 holds the base and the starting value.
    logic          r_pw_v    [NPW+1];
    logic [FB:0]   r_pw_p    [NPW+1];
    logic [FB:0]   r_pw_base [NPW+1];
    logic [XW-1:0] r_pw_cnt  [NPW+1];
    logic [FB:0]   r_pw_dif  [NPW+1];
    logic          n_pw_v    [NPW+1];
    logic [FB:0]   n_pw_p    [NPW+1];
    logic [FB:0]   n_pw_base [NPW+1];
    logic [XW-1:0] n_pw_cnt  [NPW+1];
    logic [FB:0]   n_pw_dif  [NPW+1];

    function automatic logic [FB:0] clamp_dot(input logic signed [SMW-1:0] s);
        logic [SMW-1:0] q;
        q = SMW'(s >>> FB);
        if (s <= 0) begin
            clamp_dot = '0;
        end else if (q > SMW'(ONE)) begin
            clamp_dot = ONE;
        end else begin
            clamp_dot = q[FB:0];
        end
    endfunction

    function automatic logic [phong_pkg::OUT_W-1:0] sat_out(input logic [FB:0] v);
        logic [SATW-1:0] x;
        x = SATW'(v);
        if (x > SATW'(phong_pkg::OUT_MAX)) begin
            sat_out = phong_pkg::OUT_MAX;
        end else begin
            sat_out = x[phong_pkg::OUT_W-1:0];
        end
    endfunction

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light[0]  <= '0;
            r_light[1]  <= '0;
            r_light[2]  <= LW'(16384);
            r_exp_plain <= XW'(32);
            r_exp_tex   <= XW'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                phong_pkg::REG_LIGHT_X:   r_light[0]  <= i_cfg_data;
                phong_pkg::REG_LIGHT_Y:   r_light[1]  <= i_cfg_data;
                phong_pkg::REG_LIGHT_Z:   r_light[2]  <= i_cfg_data;
                phong_pkg::REG_EXP_PLAIN: r_exp_plain <= i_cfg_data[XW-1:0];
                phong_pkg::REG_EXP_TEX:   r_exp_tex   <= i_cfg_data[XW-1:0];
                default: ;
            endcase
        end
    end

    assign vn = {i_pix.normal_z, i_pix.normal_y, i_pix.normal_x};
    assign ve = {i_pix.eye_z, i_pix.eye_y, i_pix.eye_x};

    phong_norm #(.VW(LW), .FB(FB), .SBW(1)) u_norm_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_vec   (vn),
        .i_sb    (i_pix.textured),
        .o_valid (nn_v),
        .o_unit  (nn_u),
        .o_ok    (),
        .o_sb    (nn_sb)
    );

    phong_norm #(.VW(LW), .FB(FB), .SBW(1)) u_norm_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_vec   (ve),
        .i_sb    (1'b0),
        .o_valid (ne_v),
        .o_unit  (ne_u),
        .o_ok    (ne_ok),
        .o_sb    ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_c1_v <= 1'b0;
        end else if (adv) begin
            r_b1_v <= nn_v && ne_v;
            r_b2_v <= r_b1_v;
            r_c1_v <= nr_v;
        end
    end

    // A zero-length normal gives a zero unit vector, so the dot product is
    // already zero without a separate flag.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_b1_pl[i] <= $signed(nn_u[i]) * r_light[i];
                r_b1_d[i]  <= DW'($signed(nn_u[i])) - DW'(r_light[i]);
            end
            r_b1_eu  <= ne_u;
            r_b1_eok <= ne_ok;
            r_b1_tex <= nn_sb;

            r_b2_dif <= clamp_dot(SMW'(r_b1_pl[0]) + SMW'(r_b1_pl[1]) + SMW'(r_b1_pl[2]));
            r_b2_d   <= r_b1_d;
            r_b2_eu  <= r_b1_eu;
            r_b2_eok <= r_b1_eok;
            r_b2_tex <= r_b1_tex;

            for (int i = 0; i < 3; i++) begin
                r_c1_pr[i] <= $signed(rsb_out.eu[i]) * $signed(nr_u[i]);
            end
            r_c1_ok  <= nr_ok && rsb_out.eok && (rsb_out.dif != '0);
            r_c1_dif <= rsb_out.dif;
            r_c1_tex <= rsb_out.tex;
        end
    end

    assign rsb_in = '{tex: r_b2_tex, eok: r_b2_eok, dif: r_b2_dif, eu: r_b2_eu};

    phong_norm #(.VW(DW), .FB(FB), .SBW($bits(t_rsb))) u_norm_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_b2_v),
        .i_vec   (r_b2_d),
        .i_sb    (rsb_in),
        .o_valid (nr_v),
        .o_unit  (nr_u),
        .o_ok    (nr_ok),
        .o_sb    (rsb_out)
    );

    // A disabled specular term starts the chain at zero, which stays zero.
    always_comb begin
        logic [PRW-1:0] prod;
        n_pw_v[0]    = r_c1_v;
        n_pw_base[0] = clamp_dot(SMW'(r_c1_pr[0]) + SMW'(r_c1_pr[1]) + SMW'(r_c1_pr[2]));
        n_pw_p[0]    = r_c1_ok ? ONE : '0;
        n_pw_cnt[0]  = r_c1_tex ? r_exp_tex : r_exp_plain;
        n_pw_dif[0]  = r_c1_dif;
        for (int k = 0; k < NPW; k++) begin
            prod = PRW'(r_pw_p[k]) * PRW'(r_pw_base[k]);
            n_pw_v[k+1]    = r_pw_v[k];
            n_pw_base[k+1] = r_pw_base[k];
            n_pw_cnt[k+1]  = r_pw_cnt[k];
            n_pw_dif[k+1]  = r_pw_dif[k];
            if (XW'(k) < r_pw_cnt[k]) begin
                n_pw_p[k+1] = prod[FB +: FB + 1];
            end else begin
                n_pw_p[k+1] = r_pw_p[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NPW; k++) begin
                r_pw_v[k] <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k <= NPW; k++) begin
                r_pw_v[k] <= n_pw_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= NPW; k++) begin
                r_pw_p[k]    <= n_pw_p[k];
                r_pw_base[k] <= n_pw_base[k];
                r_pw_cnt[k]  <= n_pw_cnt[k];
                r_pw_dif[k]  <= n_pw_dif[k];
            end
        end
    end

    assign o_valid        = r_pw_v[NPW];
    assign o_pix.diffuse  = sat_out(r_pw_dif[NPW]);
    assign o_pix.specular = sat_out(r_pw_p[NPW]);

    `PHONG_ASSERT_IMPLY(a_spec_needs_dif, o_valid && (r_pw_p[NPW] != '0), r_pw_dif[NPW] != '0)
    `PHONG_ASSERT_IMPLY(a_out_in_range, o_valid, (r_pw_dif[NPW] <= ONE) && (r_pw_p[NPW] <= ONE))
    `PHONG_ASSERT_NEXT(a_stalled_beat_kept, o_valid && i_stall, o_valid)

endmodule

FILE: tb/phong_pixel_lighting_core_test.sv
// ----------------------------------------------------------------------------
// Phong lighting core testbench
// Drives pixel beats under random source gaps and sink stalls, across several
// light and exponent settings. Every result beat is checked field by field
// against a directed expected value or an in-bench fixed point shading model.
// ----------------------------------------------------------------------------
module phong_pixel_lighting_core_test;

    localparam int ONE        = 1 << 14;
    localparam int DRAIN_WAIT = 340;
    localparam int IDLE_LIMIT = 3000;
    localparam int N_RANDOM   = 400;

    typedef longint t_vec3 [3];

    typedef struct {
        phong_pkg::t_pix_in  pix;
        bit                  typed;
        phong_pkg::t_pix_out want;
    } t_shade_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_stall;
    phong_pkg::t_pix_in               i_pix;
    logic                             o_valid;
    logic                             i_stall;
    phong_pkg::t_pix_out              o_pix;
    logic                             i_cfg_we;
    logic [phong_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [phong_pkg::CFG_DATA_W-1:0] i_cfg_data;

    phong_pixel_lighting_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pix      (i_pix),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pix      (o_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the core's registers.
    longint   light [3];
    int       exp_plain;
    int       exp_tex;

    phong_pkg::t_pix_out shade_q [$];
    int       errors;
    int       results;
    int       lit_results;
    int       idle_cycles;
    bit       no_gaps;
    int       stall_left;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(input t_vec3 v, output t_vec3 o);
        longint unsigned len2;
        longint unsigned len;
        longint          mag;
        len2 = 0;
        foreach (v[i]) len2 += longint'(v[i] * v[i]);
        o = '{0, 0, 0};
        if (len2 == 0) return 1'b0;
        len = int_sqrt(len2);
        foreach (v[i]) begin
            mag  = (v[i] < 0) ? -v[i] : v[i];
            o[i] = longint'((mag << 14) / len);
            if (v[i] < 0) o[i] = -o[i];
        end
        return 1'b1;
    endfunction

    function automatic longint dot_clamp(t_vec3 a, t_vec3 b);
        longint s;
        longint q;
        s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        if (s <= 0) return 0;
        q = s >>> 14;
        return (q > ONE) ? ONE : q;
    endfunction

    function automatic phong_pkg::t_pix_out shade(phong_pkg::t_pix_in p);
        t_vec3    nv, ev, n, e, d, r;
        longint   dif, spec, base, pw;
        int       cnt;
        bit       nok, eok;
        phong_pkg::t_pix_out res;
        nv   = '{longint'(p.normal_x), longint'(p.normal_y), longint'(p.normal_z)};
        ev   = '{longint'(p.eye_x), longint'(p.eye_y), longint'(p.eye_z)};
        dif  = 0;
        spec = 0;
        nok  = unit_vec(nv, n);
        eok  = unit_vec(ev, e);
        if (nok) dif = dot_clamp(n, light);
        if (dif > 0 && eok) begin
            foreach (d[i]) d[i] = n[i] - light[i];
            if (unit_vec(d, r)) begin
                base = dot_clamp(e, r);
                cnt  = p.textured ? exp_tex : exp_plain;
                pw   = ONE;
                repeat (cnt) pw = (pw * base) >> 14;
                spec = (pw > ONE) ? ONE : pw;
            end
        end
        res.diffuse  = (dif > phong_pkg::OUT_MAX) ? phong_pkg::OUT_MAX
                                                  : dif[phong_pkg::OUT_W-1:0];
        res.specular = (spec > phong_pkg::OUT_MAX) ? phong_pkg::OUT_MAX
                                                   : spec[phong_pkg::OUT_W-1:0];
        return res;
    endfunction

    function automatic phong_pkg::t_pix_in make_pix(int nx, int ny, int nz,
                                                    int ex, int ey, int ez, bit tx);
        phong_pkg::t_pix_in p;
        p.normal_x = 16'(nx);
        p.normal_y = 16'(ny);
        p.normal_z = 16'(nz);
        p.eye_x    = 16'(ex);
        p.eye_y    = 16'(ey);
        p.eye_z    = 16'(ez);
        p.textured = tx;
        return p;
    endfunction

    function automatic int rand_comp();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return ONE;
        if (r == 1) return -ONE;
        if (r == 2) return 0;
        return int'($urandom_range(0, 2 * ONE)) - ONE;
    endfunction

    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task automatic send_pixel(phong_pkg::t_pix_in p, bit typed, phong_pkg::t_pix_out want);
        int g;
        i_valid <= 1'b1;
        i_pix   <= p;
        do @(posedge i_clk); while (o_stall);
        shade_q.push_back(typed ? want : shade(p));
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [phong_pkg::CFG_IDX_W-1:0] idx,
                             logic [phong_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            phong_pkg::REG_LIGHT_X:   light[0]  = longint'($signed(val));
            phong_pkg::REG_LIGHT_Y:   light[1]  = longint'($signed(val));
            phong_pkg::REG_LIGHT_Z:   light[2]  = longint'($signed(val));
            phong_pkg::REG_EXP_PLAIN: exp_plain = int'(val[7:0]);
            phong_pkg::REG_EXP_TEX:   exp_tex   = int'(val[7:0]);
            default: ;
        endcase
    endtask

    task automatic set_phase(t_vec3 lt, int ep, int et);
        i_valid <= 1'b0;
        while (shade_q.size() != 0) @(posedge i_clk);
        write_reg(phong_pkg::REG_LIGHT_X, lt[0][15:0]);
        write_reg(phong_pkg::REG_LIGHT_Y, lt[1][15:0]);
        write_reg(phong_pkg::REG_LIGHT_Z, lt[2][15:0]);
        write_reg(phong_pkg::REG_EXP_PLAIN, ep[15:0]);
        write_reg(phong_pkg::REG_EXP_TEX, et[15:0]);
        // An index past the register list must leave everything unchanged.
        write_reg(3'd5 + 3'($urandom_range(0, 2)), 16'($urandom));
        i_cfg_we <= 1'b0;
        no_gaps = ($urandom_range(0, 3) == 0);
    endtask

    // Result side: random stalls and checking.
    always @(posedge i_clk) begin
        phong_pkg::t_pix_out want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                results++;
                if (o_pix.specular != 0) lit_results++;
                if (shade_q.size() == 0) begin
                    $display("result beat with nothing outstanding");
                    errors++;
                end else begin
                    want = shade_q.pop_front();
                    if (o_pix.diffuse != want.diffuse)
                        report("diffuse", o_pix.diffuse, want.diffuse);
                    if (o_pix.specular != want.specular)
                        report("specular", o_pix.specular, want.specular);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                         : $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        t_shade_row         rows [$];
        phong_pkg::t_pix_in p;
        t_vec3              lt, raw;
        int                 k, cls;
        int                 exp_pairs [8][2];

        errors      = 0;
        results     = 0;
        lit_results = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        light       = '{0, 0, ONE};
        exp_plain   = 32;
        exp_tex     = 32;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_pix       = '0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset light (0, 0, 1.0).
        rows.push_back('{make_pix(0, 0, ONE, 0, 0, ONE, 0), 1, '{ONE, 0}});
        rows.push_back('{make_pix(0, 0, 0, 0, 0, ONE, 0), 1, '{0, 0}});
        rows.push_back('{make_pix(0, 0, -ONE, 0, 0, ONE, 1), 1, '{0, 0}});
        rows.push_back('{make_pix(ONE, 0, 0, 0, ONE, 0, 1), 1, '{0, 0}});
        rows.push_back('{make_pix(0, 0, 1, -ONE, -ONE, -ONE, 0), 1, '{ONE, 0}});
        rows.push_back('{make_pix(0, 8000, 8000, 0, 0, 0, 0), 0, '{0, 0}});
        rows.push_back('{make_pix(-ONE, -ONE, -ONE, ONE, ONE, ONE, 1), 0, '{0, 0}});
        rows.push_back('{make_pix(ONE, ONE, ONE, ONE, ONE, ONE, 0), 0, '{0, 0}});
        rows.push_back('{make_pix(5000, 0, 12000, 0, 0, ONE, 1), 0, '{0, 0}});
        rows.push_back('{make_pix(ONE, 0, ONE, 11585, 0, -4799, 0), 0, '{0, 0}});
        rows.push_back('{make_pix(ONE, 0, ONE, 11585, 0, -4799, 1), 0, '{0, 0}});
        rows.push_back('{make_pix(-1, 2, 3, -3, 1, -1, 0), 0, '{0, 0}});
        rows.push_back('{make_pix(100, -ONE, 9000, -ONE, ONE, -ONE, 1), 0, '{0, 0}});
        foreach (rows[i]) send_pixel(rows[i].pix, rows[i].typed, rows[i].want);

        // Light extremes and exponent extremes, then random unit lights.
        exp_pairs = '{'{1, 255}, '{255, 1}, '{0, 2}, '{3, 8}, '{16, 0},
                      '{1, 2}, '{64, 5}, '{2, 1}};
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: lt = '{0, 0, -ONE};
                1: lt = '{-ONE, 0, 0};
                2: lt = '{ONE, ONE, ONE};
                3: lt = '{0, ONE, 0};
                default: begin
                    raw = '{rand_comp(), rand_comp(), rand_comp()};
                    if (!unit_vec(raw, lt)) lt = '{0, 0, ONE};
                end
            endcase
            set_phase(lt, exp_pairs[ph][0], exp_pairs[ph][1]);
            for (k = 0; k < N_RANDOM / 8; k++) begin
                cls = $urandom_range(0, 99);
                p = make_pix(rand_comp(), rand_comp(), rand_comp(),
                             rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 1));
                if (cls < 5) begin
                    p.normal_x = 0;
                    p.normal_y = 0;
                    p.normal_z = 0;
                end else if (cls < 10) begin
                    p.eye_x = 0;
                    p.eye_y = 0;
                    p.eye_z = 0;
                end else if (cls < 15) begin
                    p.normal_x = 16'(light[0]);
                    p.normal_y = 16'(light[1]);
                    p.normal_z = 16'(light[2]);
                end
                send_pixel(p, 1'b0, '{0, 0});
            end
        end

        i_valid <= 1'b0;
        while (shade_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Checked %0d shaded pixels over 9 light/exponent settings", results);
        $display("%0d of them carried a nonzero specular term", lit_results);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
